[rtl/dib_pkg.sv]
`default_nettype none
package dib_pkg;

    localparam int CountWidth  = 11;
    localparam int ByteWidth   = 8;
    localparam int IdWidth     = 32;
    localparam int PosWidth    = 3;
    localparam int InDataWidth = 24;

    localparam logic [CountWidth-1:0] MAX_BLOCK_IDS = CountWidth'(1024);

    localparam logic [ByteWidth-1:0] FMT_VINT = 8'd0;
    localparam logic [ByteWidth-1:0] FMT_B24  = 8'd24;
    localparam logic [ByteWidth-1:0] FMT_B32  = 8'd32;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    localparam logic [PosWidth-1:0] VINT_MAX_BYTES = 3'd5;
    localparam logic [PosWidth-1:0] B24_BYTES      = 3'd3;
    localparam logic [PosWidth-1:0] B32_BYTES      = 3'd4;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_FORMAT = 6'b000010,
        PH_VINT   = 6'b000100,
        PH_B24    = 6'b001000,
        PH_B32    = 6'b010000,
        PH_ERROR  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic                  kind;
        logic [CountWidth-1:0] block_count;
        logic [ByteWidth-1:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic               valid;
        logic [IdWidth-1:0] doc_id;
        logic               last_of_block;
        logic               status;
    } result_t;

endpackage
`default_nettype wire

[rtl/dib_core.sv]
`default_nettype none
module dib_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire dib_pkg::item_t  item,
    output dib_pkg::result_t     res
);
    import dib_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [CountWidth-1:0] ids_left_reg, ids_left_next;
    logic [IdWidth-1:0]    acc_reg, acc_next;
    logic [PosWidth-1:0]   pos_reg, pos_next;
    logic [IdWidth-1:0]    sum_reg, sum_next;

    logic [IdWidth-1:0]    vint_acc;
    logic [IdWidth-1:0]    vint_sum;
    logic [IdWidth-1:0]    b24_acc;
    logic [IdWidth-1:0]    b32_acc;
    logic [PosWidth-1:0]   pos_inc;
    logic [CountWidth-1:0] ids_dec;
    logic [CountWidth-1:0] count_clamped;
    logic [IdWidth-1:0]    low7;

    assign low7    = IdWidth'(item.data_byte[6:0]);
    assign pos_inc = pos_reg + 3'd1;
    assign ids_dec = ids_left_reg - CountWidth'(1);
    assign count_clamped = (item.block_count > MAX_BLOCK_IDS) ? MAX_BLOCK_IDS
                                                              : item.block_count;

    always_comb
    begin
        unique case (pos_reg)
            3'd0:    vint_acc = acc_reg | low7;
            3'd1:    vint_acc = acc_reg | (low7 << 7);
            3'd2:    vint_acc = acc_reg | (low7 << 14);
            3'd3:    vint_acc = acc_reg | (low7 << 21);
            3'd4:    vint_acc = acc_reg | (low7 << 28);
            default: vint_acc = acc_reg;
        endcase
    end

    assign vint_sum = sum_reg + vint_acc;
    assign b24_acc  = {8'd0, acc_reg[15:0], item.data_byte};
    assign b32_acc  = {acc_reg[23:0], item.data_byte};

    always_comb
    begin
        phase_next    = phase_reg;
        ids_left_next = ids_left_reg;
        acc_next      = acc_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        res           = '0;
        if (item.kind == KIND_START)
        begin
            ids_left_next = count_clamped;
            acc_next      = '0;
            pos_next      = '0;
            sum_next      = '0;
            phase_next    = PH_FORMAT;
        end
        else
        begin
            unique case (phase_reg)
                PH_FORMAT:
                begin
                    if (item.data_byte == FMT_VINT || item.data_byte == FMT_B24 ||
                        item.data_byte == FMT_B32)
                    begin
                        if (ids_left_reg == '0)
                            phase_next = PH_IDLE;
                        else if (item.data_byte == FMT_VINT)
                            phase_next = PH_VINT;
                        else if (item.data_byte == FMT_B24)
                            phase_next = PH_B24;
                        else
                            phase_next = PH_B32;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                        res.valid  = 1'b1;
                        res.status = STATUS_ERROR;
                    end
                end
                PH_VINT:
                begin
                    acc_next = vint_acc;
                    pos_next = pos_inc;
                    if (!item.data_byte[7] || pos_inc >= VINT_MAX_BYTES)
                    begin
                        sum_next   = vint_sum;
                        res.valid  = 1'b1;
                        res.doc_id = vint_sum;
                    end
                end
                PH_B24:
                begin
                    acc_next = b24_acc;
                    pos_next = pos_inc;
                    if (pos_inc >= B24_BYTES)
                    begin
                        res.valid  = 1'b1;
                        res.doc_id = b24_acc;
                    end
                end
                PH_B32:
                begin
                    acc_next = b32_acc;
                    pos_next = pos_inc;
                    if (pos_inc >= B32_BYTES)
                    begin
                        res.valid  = 1'b1;
                        res.doc_id = b32_acc;
                    end
                end
                PH_IDLE, PH_ERROR:
                begin
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
            // emit an identifier: count down, clear the value, close the block on the last
            if (res.valid && res.status == STATUS_OK)
            begin
                ids_left_next     = ids_dec;
                res.last_of_block = (ids_dec == '0);
                acc_next          = '0;
                pos_next          = '0;
                if (ids_dec == '0)
                    phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            ids_left_reg <= '0;
            acc_reg      <= '0;
            pos_reg      <= '0;
            sum_reg      <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            ids_left_reg <= ids_left_next;
            acc_reg      <= acc_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
        end
    end

endmodule
`default_nettype wire

[rtl/dib_out_reg.sv]
`default_nettype none
module dib_out_reg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire dib_pkg::result_t              res,
    output logic                               free,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [dib_pkg::IdWidth-1:0]        m_axis_tdata,
    output logic                               m_axis_tlast,
    output logic                               m_axis_tuser
);
    import dib_pkg::*;

    logic               valid_reg;
    logic [IdWidth-1:0] data_reg;
    logic               last_reg;
    logic               user_reg;

    assign free          = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (m_axis_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res.doc_id;
            last_reg <= res.last_of_block;
            user_reg <= res.status;
        end
    end

endmodule
`default_nettype wire

[rtl/doc_id_block_decoder_top.sv]
// Document ID block decoder.
// Input stream: s_axis_tuser is the kind (0 = block start, 1 = data byte);
// s_axis_tdata carries block_count in [10:0] and data_byte in [18:11].
// A block start sets the ID count (clamped to 1024); the first data byte picks
// the format: 0 = delta varints, 24 = big-endian 3-byte, 32 = big-endian 4-byte.
// Output stream: m_axis_tdata is the 32-bit doc ID, m_axis_tlast marks the
// block's final ID and m_axis_tuser is the status (1 = unsupported format,
// with ID 0). After an error, bytes are dropped until the next block start.
// An accepted transaction lands in the input register and is decoded
// into the result register, which drives m_axis_tvalid. Throughput is one
// byte per cycle while the receiver keeps up, set by the single decode stage
// between those two registers. Reset clears the valid bits of both registers
// and puts the decoder idle with no block open.
// When the receiver stalls, the result register holds; items that give no
// result keep flowing, and an item that gives one waits in the input register,
// which drops s_axis_tready.
`default_nettype none
module doc_id_block_decoder_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [10:0] block_count, [18:11] data_byte, [23:19] zero
    input  wire logic [dib_pkg::InDataWidth-1:0] s_axis_tdata,
    // [0] kind
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [31:0] doc_id
    output logic [dib_pkg::IdWidth-1:0]          m_axis_tdata,
    output logic                                 m_axis_tlast,
    // [0] status
    output logic                                 m_axis_tuser
);
    import dib_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    result_t res;
    logic    out_free;
    logic    advance;

    assign advance       = in_valid_reg && (!res.valid || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.kind        <= s_axis_tuser;
            in_item_reg.block_count <= s_axis_tdata[CountWidth-1:0];
            in_item_reg.data_byte   <= s_axis_tdata[CountWidth+ByteWidth-1:CountWidth];
        end
    end

    dib_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .res   (res)
    );

    dib_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && res.valid),
        .res           (res),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire
